// File: hdl/abs_pkg.sv
// ---------------------------------------------------------------------------
// abs_pkg
// Shared types and constants of the alternating-bit sender: codes, widths,
// the command passed from front to back and the result word.
// ---------------------------------------------------------------------------
package abs_pkg;

  // payload bytes per packet
  localparam int PAYLOAD_BYTES = 20;
  // byte position counts 0..PAYLOAD_BYTES
  localparam int POS_W  = $clog2(PAYLOAD_BYTES + 1);
  localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int CHK_W  = 14;
  localparam int ACK_W  = 19;

  // command queue and result queue geometry
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;
  localparam int CMDQ_CW    = 3;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  // input actions
  localparam logic [1:0] ACT_MSG = 2'd0;
  localparam logic [1:0] ACT_ACK = 2'd1;
  localparam logic [1:0] ACT_TMO = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_TRAILER = 2'd1;
  localparam logic [1:0] KIND_CTRL    = 2'd2;

  // back-end operations
  localparam logic [1:0] OP_MSG    = 2'd0;
  localparam logic [1:0] OP_CTRL   = 2'd1;
  localparam logic [1:0] OP_REPLAY = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic                    has_byte;
    logic [7:0]              data;
    logic [POS_W-1:0]        pos;
    logic                    last;
    logic                    seq;
    logic                    ack;
    logic signed [CHK_W-1:0] chk;
    logic                    start;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [7:0]              data;
    logic                    seq;
    logic                    ack;
    logic signed [CHK_W-1:0] chk;
    logic                    start;
    logic                    stop;
    logic                    eor;
  } res_t;

endpackage

// File: hdl/abs_ram.sv
// ---------------------------------------------------------------------------
// abs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module abs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/abs_front.sv
// ---------------------------------------------------------------------------
// abs_front
// Front end: accepts input beats, keeps the protocol state (sequence and ack
// bits, in-flight, byte position, running sum) and issues back-end commands.
// ---------------------------------------------------------------------------
module abs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [1:0]                 action,
  input  logic [7:0]                 payload_byte,
  input  logic                       is_last_byte,
  input  logic [15:0]                ack_seq_field,
  input  logic [15:0]                ack_ack_field,
  input  logic signed [abs_pkg::ACK_W-1:0] ack_check_field,
  output logic                       cmd_push,
  output abs_pkg::cmd_t              cmd
);
  localparam int POS_W = abs_pkg::POS_W;
  localparam int CHK_W = abs_pkg::CHK_W;
  localparam int ACK_W = abs_pkg::ACK_W;

  logic                    seq_r, seq_nxt;
  logic                    exp_r, exp_nxt;
  logic                    inflight_r, inflight_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [CHK_W-1:0] sum_r, sum_nxt;
  logic                    zs_r, zs_nxt;
  logic                    drop_r, drop_nxt;

  logic                    has_room;
  logic [7:0]              byte_eff;
  logic signed [CHK_W-1:0] msg_sum;
  logic signed [CHK_W-1:0] ack_sum;
  logic [ACK_W-1:0]        ack_total;
  logic                    intact;
  logic                    ack_match;

  // arithmetic shared by the decode below
  always_comb begin
    has_room  = pos_r < POS_W'(abs_pkg::PAYLOAD_BYTES);
    byte_eff  = zs_r ? 8'd0 : payload_byte;
    msg_sum   = has_room ? sum_r + {{(CHK_W-8){byte_eff[7]}}, byte_eff} : sum_r;
    ack_sum   = has_room ? sum_r + {{(CHK_W-8){payload_byte[7]}}, payload_byte} : sum_r;
    ack_total = {{(ACK_W-CHK_W){ack_sum[CHK_W-1]}}, ack_sum}
              + {{(ACK_W-16){1'b0}}, ack_seq_field}
              + {{(ACK_W-16){1'b0}}, ack_ack_field};
    intact    = ack_total == ack_check_field;
    ack_match = ack_ack_field == {15'd0, exp_r};
  end

  // action decode and command build
  always_comb begin
    seq_nxt      = seq_r;
    exp_nxt      = exp_r;
    inflight_nxt = inflight_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    zs_nxt       = zs_r;
    drop_nxt     = drop_r;
    cmd_push     = 1'b0;
    cmd          = '0;
    cmd.pos      = pos_r;
    cmd.data     = byte_eff;
    cmd.has_byte = has_room;
    cmd.last     = is_last_byte;
    cmd.seq      = seq_r;
    cmd.ack      = exp_r;
    cmd.chk      = msg_sum + CHK_W'(seq_r) + CHK_W'(exp_r);
    if (accept) begin
      unique case (action)
        abs_pkg::ACT_MSG: begin
          if (drop_r) begin
            if (is_last_byte) drop_nxt = 1'b0;
          end else if (pos_r == '0 && inflight_r) begin
            drop_nxt = !is_last_byte;
          end else begin
            if (byte_eff == 8'd0) zs_nxt = 1'b1;
            if (has_room) begin
              pos_nxt = pos_r + POS_W'(1);
              sum_nxt = msg_sum;
            end
            cmd.op   = abs_pkg::OP_MSG;
            cmd_push = has_room || is_last_byte;
            if (is_last_byte) begin
              inflight_nxt = 1'b1;
              pos_nxt      = '0;
              sum_nxt      = '0;
              zs_nxt       = 1'b0;
            end
          end
        end
        abs_pkg::ACT_ACK: begin
          if (has_room) begin
            pos_nxt = pos_r + POS_W'(1);
            sum_nxt = ack_sum;
          end
          if (is_last_byte) begin
            pos_nxt = '0;
            sum_nxt = '0;
            if (intact && ack_match) begin
              cmd.op       = abs_pkg::OP_CTRL;
              cmd_push     = 1'b1;
              exp_nxt      = !exp_r;
              seq_nxt      = !seq_r;
              inflight_nxt = 1'b0;
            end else if (!intact) begin
              cmd.op    = abs_pkg::OP_REPLAY;
              cmd.start = 1'b0;
              cmd_push  = 1'b1;
            end
          end
        end
        abs_pkg::ACT_TMO: begin
          cmd.op    = abs_pkg::OP_REPLAY;
          cmd.start = 1'b1;
          cmd_push  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // protocol state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r      <= 1'b0;
      exp_r      <= 1'b0;
      inflight_r <= 1'b0;
      pos_r      <= '0;
      sum_r      <= '0;
      zs_r       <= 1'b0;
      drop_r     <= 1'b0;
    end else begin
      seq_r      <= seq_nxt;
      exp_r      <= exp_nxt;
      inflight_r <= inflight_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      zs_r       <= zs_nxt;
      drop_r     <= drop_nxt;
    end
  end

endmodule

// File: hdl/abs_cmd_queue.sv
// ---------------------------------------------------------------------------
// abs_cmd_queue
// Short command queue between front and back end.
// ---------------------------------------------------------------------------
module abs_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  abs_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output abs_pkg::cmd_t rd_data
);
  localparam int AW = abs_pkg::CMDQ_AW;
  localparam int CW = abs_pkg::CMDQ_CW;

  abs_pkg::cmd_t   mem_r [abs_pkg::CMDQ_DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign full     = cnt_r == CW'(abs_pkg::CMDQ_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + CW'(1);
    if (!do_wr && do_rd) cnt_nxt = cnt_r - CW'(1);
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + AW'(1);
      if (do_rd) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// File: hdl/abs_back.sv
// ---------------------------------------------------------------------------
// abs_back
// Back end: executes commands, owns the packet store, pads and closes packets,
// replays the stored packet and queues result beats.
// ---------------------------------------------------------------------------
module abs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  abs_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          res_empty,
  input  logic          res_pop,
  output abs_pkg::res_t res
);
  localparam int POS_W  = abs_pkg::POS_W;
  localparam int ADDR_W = abs_pkg::ADDR_W;
  localparam int CHK_W  = abs_pkg::CHK_W;
  localparam int QAW    = abs_pkg::OUTQ_AW;
  localparam int QCW    = abs_pkg::OUTQ_CW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_RPL  = 2'd2;

  logic [1:0]              st_r, st_nxt;
  logic [POS_W-1:0]        idx_r, idx_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic                    start_r, start_nxt;
  logic                    pad_ack_r, pad_ack_nxt;
  logic                    sseq_r, sseq_nxt;
  logic signed [CHK_W-1:0] schk_r, schk_nxt;

  // packet store ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // result queue
  abs_pkg::res_t  oq_r [abs_pkg::OUTQ_DEPTH];
  logic [QAW-1:0] owp_r, orp_r;
  logic [QCW-1:0] ocnt_r, ocnt_nxt;
  logic           push_v;
  abs_pkg::res_t  push_d;
  logic           oq_room;
  logic           do_pop;
  logic           idx_end;
  logic           can_issue;

  assign oq_room   = ocnt_r < QCW'(abs_pkg::OUTQ_DEPTH);
  assign idx_end   = idx_r == POS_W'(abs_pkg::PAYLOAD_BYTES);
  assign can_issue = ({1'b0, ocnt_r} + (QCW+1)'(rd_pend_r) + (QCW+1)'(1))
                     <= (QCW+1)'(abs_pkg::OUTQ_DEPTH);

  abs_ram #(
    .WIDTH (8),
    .DEPTH (abs_pkg::PAYLOAD_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command sequencer
  always_comb begin
    st_nxt      = st_r;
    idx_nxt     = idx_r;
    rd_pend_nxt = 1'b0;
    start_nxt   = start_r;
    pad_ack_nxt = pad_ack_r;
    sseq_nxt    = sseq_r;
    schk_nxt    = schk_r;
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_r[ADDR_W-1:0];
    ram_wdata   = 8'd0;
    ram_re      = 1'b0;
    ram_raddr   = idx_r[ADDR_W-1:0];
    push_v      = 1'b0;
    push_d      = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid && oq_room) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            abs_pkg::OP_MSG: begin
              if (cmd.has_byte) begin
                ram_we      = 1'b1;
                ram_waddr   = cmd.pos[ADDR_W-1:0];
                ram_wdata   = cmd.data;
                push_v      = 1'b1;
                push_d.kind = abs_pkg::KIND_BYTE;
                push_d.data = cmd.data;
                push_d.eor  = !cmd.last;
              end
              if (cmd.last) begin
                st_nxt      = ST_PAD;
                idx_nxt     = cmd.pos + POS_W'(cmd.has_byte);
                sseq_nxt    = cmd.seq;
                pad_ack_nxt = cmd.ack;
                schk_nxt    = cmd.chk;
              end
            end
            abs_pkg::OP_CTRL: begin
              push_v      = 1'b1;
              push_d.kind = abs_pkg::KIND_CTRL;
              push_d.stop = 1'b1;
              push_d.eor  = 1'b1;
            end
            abs_pkg::OP_REPLAY: begin
              st_nxt    = ST_RPL;
              idx_nxt   = '0;
              start_nxt = cmd.start;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PAD: begin
        if (oq_room) begin
          push_v = 1'b1;
          if (!idx_end) begin
            // zero fill up to the packet length
            ram_we      = 1'b1;
            push_d.kind = abs_pkg::KIND_BYTE;
            idx_nxt     = idx_r + POS_W'(1);
          end else begin
            push_d.kind  = abs_pkg::KIND_TRAILER;
            push_d.seq   = sseq_r;
            push_d.ack   = pad_ack_r;
            push_d.chk   = schk_r;
            push_d.start = 1'b1;
            push_d.eor   = 1'b1;
            st_nxt       = ST_IDLE;
          end
        end
      end
      ST_RPL: begin
        // read issued last cycle lands now; space was reserved at issue
        if (rd_pend_r) begin
          push_v      = 1'b1;
          push_d.kind = abs_pkg::KIND_BYTE;
          push_d.data = ram_rdata;
        end
        if (!idx_end && can_issue) begin
          ram_re      = 1'b1;
          idx_nxt     = idx_r + POS_W'(1);
          rd_pend_nxt = 1'b1;
        end
        if (idx_end && !rd_pend_r && oq_room) begin
          push_v       = 1'b1;
          push_d.kind  = abs_pkg::KIND_TRAILER;
          push_d.seq   = sseq_r;
          push_d.ack   = sseq_r;
          push_d.chk   = schk_r;
          push_d.start = start_r;
          push_d.eor   = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
      start_r   <= 1'b0;
      pad_ack_r <= 1'b0;
      sseq_r    <= 1'b0;
      schk_r    <= '0;
    end else begin
      st_r      <= st_nxt;
      idx_r     <= idx_nxt;
      rd_pend_r <= rd_pend_nxt;
      start_r   <= start_nxt;
      pad_ack_r <= pad_ack_nxt;
      sseq_r    <= sseq_nxt;
      schk_r    <= schk_nxt;
    end
  end

  // result queue
  assign res_empty = ocnt_r == '0;
  assign res       = oq_r[orp_r];
  assign do_pop    = res_pop && !res_empty;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (push_v && !do_pop) ocnt_nxt = ocnt_r + QCW'(1);
    if (!push_v && do_pop) ocnt_nxt = ocnt_r - QCW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (push_v) owp_r <= owp_r + QAW'(1);
      if (do_pop) orp_r <= orp_r + QAW'(1);
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_v) begin
      oq_r[owp_r] <= push_d;
    end
  end

`ifndef SYNTHESIS
  // a beat is never pushed into a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_v |-> ocnt_r < QCW'(abs_pkg::OUTQ_DEPTH))
    else $error("result queue overflow");

  // a pending store read only exists during replay
  a_pend_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> st_r == ST_RPL)
    else $error("store read pending outside replay");

  // byte index never runs past the packet length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= POS_W'(abs_pkg::PAYLOAD_BYTES))
    else $error("byte index out of range");

  // commands are taken only when idle
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> st_r == ST_IDLE && cmd_valid)
    else $error("command taken while busy");
`endif

endmodule

// File: hdl/alternating_bit_sender_core.sv
// ---------------------------------------------------------------------------
// alternating_bit_sender_core
// Stop-and-wait sender: a front end tracks the protocol state per input beat,
// a back end forwards, pads, closes and replays packets from the store.
// ---------------------------------------------------------------------------
// The first result beat of an input beat passes the command queue and the result queue,
//   both registered; a replay also passes the registered store read.
// Throughput: one input beat per cycle into the 4-entry command queue while it is not
//   full; the back end takes a new command only when idle, after padding and closing
//   a packet or replaying the store, and slows further while results back up.
// Reset: synchronous, active low; clears protocol state and both queues, not the store.
module alternating_bit_sender_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       in_action,
  input  logic [7:0]                       in_payload_byte,
  input  logic                             in_is_last_byte,
  input  logic [15:0]                      in_ack_seq_field,
  input  logic [15:0]                      in_ack_ack_field,
  input  logic signed [abs_pkg::ACK_W-1:0] in_ack_check_field,
  output logic                             empty,
  input  logic                             pop,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_out_byte,
  output logic                             out_out_seq,
  output logic                             out_out_ack,
  output logic signed [abs_pkg::CHK_W-1:0] out_out_checksum,
  output logic                             out_start_timer,
  output logic                             out_stop_timer,
  output logic                             out_end_of_run
);
  logic          accept;
  logic          cmd_push;
  abs_pkg::cmd_t cmd_in;
  logic          cmd_valid;
  abs_pkg::cmd_t cmd_out;
  logic          cmd_pop;
  abs_pkg::res_t res;

  assign accept = push && !full;

  abs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .action          (in_action),
    .payload_byte    (in_payload_byte),
    .is_last_byte    (in_is_last_byte),
    .ack_seq_field   (in_ack_seq_field),
    .ack_ack_field   (in_ack_ack_field),
    .ack_check_field (in_ack_check_field),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in)
  );

  abs_cmd_queue u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_push),
    .wr_data  (cmd_in),
    .full     (full),
    .rd_en    (cmd_pop),
    .rd_valid (cmd_valid),
    .rd_data  (cmd_out)
  );

  abs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_empty (empty),
    .res_pop   (pop),
    .res       (res)
  );

  // result beat fields
  assign out_kind         = res.kind;
  assign out_out_byte     = res.data;
  assign out_out_seq      = res.seq;
  assign out_out_ack      = res.ack;
  assign out_out_checksum = res.chk;
  assign out_start_timer  = res.start;
  assign out_stop_timer   = res.stop;
  assign out_end_of_run   = res.eor;

endmodule

// File: tb/alternating_bit_sender_core_test.sv
// ---------------------------------------------------------------------------
// alternating_bit_sender_core_test
// Self-checking bench for the stop-and-wait sender. Message, ack and timer
// beats go in through the push/full queue; a mirror of the sender's protocol
// state predicts every network beat, and each popped beat is compared field
// by field against the oldest prediction.
// ---------------------------------------------------------------------------
module alternating_bit_sender_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import abs_pkg::*;

  // unused action code, must be ignored by the sender
  localparam logic [1:0] ACT_NOP = 2'd3;

  // flavors of incoming ack
  localparam int ACK_GOOD   = 0;  // intact, ack field matches
  localparam int ACK_STALE  = 1;  // intact, ack field does not match
  localparam int ACK_BAD    = 2;  // checksum broken
  localparam int ACK_RANDOM = 3;  // anything goes

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_BEATS  = 60;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    push = 1'b0;
  logic                    full;
  logic [1:0]              in_action = ACT_MSG;
  logic [7:0]              in_payload_byte = 8'h00;
  logic                    in_is_last_byte = 1'b0;
  logic [15:0]             in_ack_seq_field = 16'h0000;
  logic [15:0]             in_ack_ack_field = 16'h0000;
  logic signed [ACK_W-1:0] in_ack_check_field = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [1:0]              out_kind;
  logic [7:0]              out_out_byte;
  logic                    out_out_seq;
  logic                    out_out_ack;
  logic signed [CHK_W-1:0] out_out_checksum;
  logic                    out_start_timer;
  logic                    out_stop_timer;
  logic                    out_end_of_run;

  int send_idle_pct = 30;
  int recv_idle_pct = 65;
  int beats_sent = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  // mirror of the sender's protocol state
  logic                    m_seq = 1'b0;
  logic                    m_exp_ack = 1'b0;
  logic                    m_in_flight = 1'b0;
  logic                    m_zero_seen = 1'b0;
  logic                    m_dropping = 1'b0;
  logic                    m_pkt_sent = 1'b0;  // store fully written once
  logic [7:0]              m_store [PAYLOAD_BYTES];
  logic signed [CHK_W-1:0] m_chk = '0;
  logic                    m_store_seq = 1'b0;
  logic [POS_W-1:0]        m_pos = '0;
  logic signed [ACK_W-1:0] m_sum = '0;

  // network beats of the current input beat, then all beats still owed
  res_t step_beats [$];
  res_t tx_due [$];

  alternating_bit_sender_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_action          (in_action),
    .in_payload_byte    (in_payload_byte),
    .in_is_last_byte    (in_is_last_byte),
    .in_ack_seq_field   (in_ack_seq_field),
    .in_ack_ack_field   (in_ack_ack_field),
    .in_ack_check_field (in_ack_check_field),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_out_byte       (out_out_byte),
    .out_out_seq        (out_out_seq),
    .out_out_ack        (out_out_ack),
    .out_out_checksum   (out_out_checksum),
    .out_start_timer    (out_start_timer),
    .out_stop_timer     (out_stop_timer),
    .out_end_of_run     (out_end_of_run)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void emit_beat(input logic [1:0] kind, input logic [7:0] data,
                                    input logic seq, input logic ack,
                                    input logic signed [CHK_W-1:0] chk,
                                    input logic start, input logic stop);
    res_t r;
    r.kind  = kind;
    r.data  = data;
    r.seq   = seq;
    r.ack   = ack;
    r.chk   = chk;
    r.start = start;
    r.stop  = stop;
    r.eor   = 1'b0;
    step_beats.push_back(r);
  endfunction

  // resend the whole stored packet and its trailer
  function automatic void replay_stored(input logic start);
    int i;
    for (i = 0; i < PAYLOAD_BYTES; i++)
      emit_beat(KIND_BYTE, m_store[i], 1'b0, 1'b0, '0, 1'b0, 1'b0);
    emit_beat(KIND_TRAILER, 8'h00, m_store_seq, m_store_seq, m_chk, start, 1'b0);
  endfunction

  function automatic void tx_predict(input logic [1:0] act, input logic [7:0] byte_in,
                                     input logic last, input logic [15:0] seq_f,
                                     input logic [15:0] ack_f,
                                     input logic signed [ACK_W-1:0] check_f);
    logic [7:0] b;
    int         total;
    int         i;
    res_t       r;
    b = byte_in;
    case (act)
      ACT_MSG: begin
        if (m_dropping) begin
          // a dropped message stays dropped through its last byte
          if (last) m_dropping = 1'b0;
        end else if (m_pos == 0 && m_in_flight) begin
          m_dropping = !last;
        end else begin
          // after the first zero byte everything goes out as zero
          if (m_zero_seen) b = 8'h00;
          if (b == 8'h00) m_zero_seen = 1'b1;
          if (m_pos < PAYLOAD_BYTES) begin
            m_store[m_pos] = b;
            m_sum += $signed(b);
            m_pos += 1'b1;
            emit_beat(KIND_BYTE, b, 1'b0, 1'b0, '0, 1'b0, 1'b0);
          end
          if (last) begin
            // pad short messages, then close the packet
            while (m_pos < PAYLOAD_BYTES) begin
              m_store[m_pos] = 8'h00;
              m_pos += 1'b1;
              emit_beat(KIND_BYTE, 8'h00, 1'b0, 1'b0, '0, 1'b0, 1'b0);
            end
            m_chk = CHK_W'(int'(m_sum) + int'(m_seq) + int'(m_exp_ack));
            m_store_seq = m_seq;
            emit_beat(KIND_TRAILER, 8'h00, m_seq, m_exp_ack, m_chk, 1'b1, 1'b0);
            m_in_flight = 1'b1;
            m_pkt_sent  = 1'b1;
            m_pos       = '0;
            m_sum       = '0;
            m_zero_seen = 1'b0;
          end
        end
      end
      ACT_ACK: begin
        if (m_pos < PAYLOAD_BYTES) begin
          m_sum += $signed(b);
          m_pos += 1'b1;
        end
        if (last) begin
          total = int'(m_sum) + int'(seq_f) + int'(ack_f);
          m_pos = '0;
          m_sum = '0;
          if (total == int'(check_f) && ack_f == {15'd0, m_exp_ack}) begin
            emit_beat(KIND_CTRL, 8'h00, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            m_exp_ack   = ~m_exp_ack;
            m_seq       = ~m_seq;
            m_in_flight = 1'b0;
          end else if (total != int'(check_f)) begin
            replay_stored(1'b0);
          end
        end
      end
      ACT_TMO: replay_stored(1'b1);
      default: ;
    endcase
    // flag the closing beat of this step
    for (i = 0; i < step_beats.size(); i++) begin
      r = step_beats[i];
      r.eor = (i == step_beats.size() - 1);
      tx_due.push_back(r);
    end
    step_beats.delete();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [1:0] act, input logic [7:0] b, input logic last,
                           input logic [15:0] seq_f, input logic [15:0] ack_f,
                           input logic signed [ACK_W-1:0] check_f);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push               <= 1'b1;
    in_action          <= act;
    in_payload_byte    <= b;
    in_is_last_byte    <= last;
    in_ack_seq_field   <= seq_f;
    in_ack_ack_field   <= ack_f;
    in_ack_check_field <= check_f;
    @(posedge clk);
    while (full) @(posedge clk);
    tx_predict(act, b, last, seq_f, ack_f, check_f);
    if (act != ACT_NOP) beats_sent++;
  endtask

  // message bytes with random content; close marks the last one
  task automatic send_msg_bytes(input int n, input logic close);
    int         i;
    logic [7:0] b;
    for (i = 0; i < n; i++) begin
      b = ($urandom_range(0, 99) < 8) ? 8'h00 : 8'($urandom);
      send_beat(ACT_MSG, b, close && (i == n - 1), 16'($urandom), 16'($urandom),
                ACK_W'($urandom));
    end
  endtask

  // ack of n bytes; the trailer fields are built from the mirrored sums
  task automatic send_ack(input int flavor, input int n);
    int                      i;
    int                      total;
    logic [7:0]              b;
    logic [15:0]             seq_f;
    logic [15:0]             ack_f;
    logic signed [ACK_W-1:0] check_f;
    for (i = 0; i < n; i++) begin
      b       = 8'($urandom);
      seq_f   = 16'($urandom);
      ack_f   = 16'($urandom);
      check_f = ACK_W'($urandom);
      if (i == n - 1) begin
        case (flavor)
          ACK_GOOD: ack_f = {15'd0, m_exp_ack};
          ACK_STALE: begin
            if ($urandom_range(0, 1)) ack_f = {15'd0, ~m_exp_ack};
            if (ack_f == {15'd0, m_exp_ack}) ack_f[0] = ~ack_f[0];
          end
          default: if ($urandom_range(0, 1)) ack_f = 16'($urandom_range(0, 1));
        endcase
        total = int'(m_sum) + ((m_pos < PAYLOAD_BYTES) ? int'($signed(b)) : 0) +
                int'(seq_f) + int'(ack_f);
        case (flavor)
          ACK_GOOD, ACK_STALE: check_f = ACK_W'(total);
          ACK_BAD: check_f = ACK_W'(total + int'($urandom_range(1, (1 << ACK_W) - 1)));
          default: if ($urandom_range(0, 1)) check_f = ACK_W'(total);
        endcase
        // no replay until a whole packet sits in the store
        if (!m_pkt_sent) check_f = ACK_W'(total);
      end
      send_beat(ACT_ACK, b, i == n - 1, seq_f, ack_f, check_f);
    end
  endtask

  function automatic int msg_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, PAYLOAD_BYTES - 1);
    if (r < 80) return PAYLOAD_BYTES;
    return $urandom_range(PAYLOAD_BYTES + 1, PAYLOAD_BYTES + 4);
  endfunction

  function automatic int ack_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(PAYLOAD_BYTES - 2, PAYLOAD_BYTES + 3);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // byte extremes, a short message, and zero fill after the first zero byte
  task automatic test_new_packets();
    send_beat(ACT_MSG, 8'h7F, 1'b0, 16'h0000, 16'h0000, '0);
    send_beat(ACT_MSG, 8'h80, 1'b0, 16'hFFFF, 16'hFFFF, '1);
    send_beat(ACT_MSG, 8'hFF, 1'b1, 16'($urandom), 16'($urandom), ACK_W'($urandom));
    send_ack(ACK_GOOD, 1);
    send_beat(ACT_MSG, 8'h01, 1'b0, 16'($urandom), 16'($urandom), ACK_W'($urandom));
    send_beat(ACT_MSG, 8'h00, 1'b0, 16'($urandom), 16'($urandom), ACK_W'($urandom));
    send_beat(ACT_MSG, 8'h55, 1'b1, 16'($urandom), 16'($urandom), ACK_W'($urandom));
  endtask

  // message while in flight; drop holds through its last byte despite an ack
  task automatic test_dropped_message();
    send_beat(ACT_MSG, 8'h11, 1'b0, 16'($urandom), 16'($urandom), ACK_W'($urandom));
    send_ack(ACK_GOOD, 1);
    send_beat(ACT_MSG, 8'h22, 1'b1, 16'($urandom), 16'($urandom), ACK_W'($urandom));
    send_beat(ACT_MSG, 8'h5A, 1'b1, 16'($urandom), 16'($urandom), ACK_W'($urandom));
    // single-byte message while in flight
    send_beat(ACT_MSG, 8'h66, 1'b1, 16'($urandom), 16'($urandom), ACK_W'($urandom));
  endtask

  // timer expiry, corrupt acks at the check field extremes, stale ack
  task automatic test_replays();
    send_beat(ACT_TMO, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
              ACK_W'($urandom));
    send_beat(ACT_ACK, 8'h80, 1'b1, 16'hFFFF, 16'h0000, 19'h40000);
    send_beat(ACT_ACK, 8'h7F, 1'b1, 16'h0000, 16'hFFFF, 19'h3FFFF);
    send_ack(ACK_STALE, 1);
    send_ack(ACK_GOOD, 1);
  endtask

  // ack with nothing in flight, short ack, unused action, ack inside a message
  task automatic test_idle_and_mixed_acks();
    send_ack(ACK_GOOD, 1);
    send_ack(ACK_GOOD, 2);
    send_beat(ACT_NOP, 8'($urandom), 1'b1, 16'($urandom), 16'($urandom), ACK_W'($urandom));
    send_beat(ACT_MSG, 8'h33, 1'b0, 16'($urandom), 16'($urandom), ACK_W'($urandom));
    send_ack(ACK_GOOD, 1);
    send_beat(ACT_MSG, 8'h44, 1'b1, 16'($urandom), 16'($urandom), ACK_W'($urandom));
  endtask

  // mostly well-formed exchanges with random content, plus noise
  task automatic test_random_traffic(input int s_pct, input int r_pct);
    int stop_at;
    int r;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = beats_sent + PHASE_BEATS;
    while (beats_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if (m_in_flight) send_ack(ACK_GOOD, ack_len());
        else send_msg_bytes(msg_len(), 1'b1);
      end else if (r < 55) begin
        send_msg_bytes(msg_len(), 1'b1);
      end else if (r < 63) begin
        if (m_pkt_sent)
          send_beat(ACT_TMO, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                    ACK_W'($urandom));
      end else if (r < 71) begin
        send_ack(ACK_BAD, ack_len());
      end else if (r < 78) begin
        send_ack(ACK_STALE, ack_len());
      end else if (r < 85) begin
        // message cut short by an ack
        send_msg_bytes($urandom_range(1, 3), 1'b0);
        send_ack(ACK_GOOD, ack_len());
      end else if (r < 90) begin
        if ($urandom_range(0, 1))
          send_beat(ACT_NOP, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                    ACK_W'($urandom));
        else
          send_beat(ACT_ACK, 8'($urandom), 1'b0, 16'($urandom), 16'($urandom),
                    ACK_W'($urandom));
      end else begin
        send_ack(ACK_RANDOM, ack_len());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void cmp(input string what, input integer want, input integer got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // receiver stalls at random
  always @(negedge clk) pop <= ($urandom_range(0, 99) >= recv_idle_pct);

  // each popped beat against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (tx_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual kind %0d byte %0d",
                 $time, out_kind, out_out_byte);
        mismatches++;
      end else begin
        want = tx_due.pop_front();
        cmp("kind", want.kind, out_kind);
        cmp("byte", want.data, out_out_byte);
        cmp("seq", want.seq, out_out_seq);
        cmp("ack", want.ack, out_out_ack);
        cmp("checksum", $signed(want.chk), $signed(out_out_checksum));
        cmp("start_timer", want.start, out_start_timer);
        cmp("stop_timer", want.stop, out_stop_timer);
        cmp("end_of_run", want.eor, out_end_of_run);
      end
    end
  end

  // watchdog: cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_new_packets();
    test_dropped_message();
    test_replays();
    test_idle_and_mixed_acks();
    test_random_traffic(30, 65);
    test_random_traffic(65, 30);
    test_random_traffic(0, 0);

    @(negedge clk) push <= 1'b0;
    while (tx_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && tx_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
